// ----- hw/rtl/lfs_pkg.sv -----
package lfs_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned BRIGHT_W = 18;
  localparam int unsigned ERR_W    = 19;
  localparam int unsigned DERIV_W  = 20;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MODE_W   = 2;

  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned GAIN_FRACTION_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF        = 4;

  localparam logic [TIME_W-1:0]   DEFAULT_INTERVAL = 32'd5;
  localparam int                  DEAD_ZONE        = 200;
  localparam logic [PERIOD_W-1:0] TURN_THRESHOLD   = 16'd800;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ON_LEFT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_AMOUNT   = 3'd7;

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_FORWARD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TURN_RIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TURN_LEFT  = 2'd2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [PERIOD_W-1:0]      base_period;
    logic [PERIOD_W-1:0]      min_period;
    logic [PERIOD_W-1:0]      max_period;
    logic [CHAN_W-1:0]        update_interval;
    logic                     offset_on_left;
    logic [CHAN_W-1:0]        offset_amount;
  } cfg_t;

  // One queue entry: was the item an update, and its error
  typedef struct packed {
    logic                    updated;
    logic signed [ERR_W-1:0] err;
  } q_entry_t;

  localparam int unsigned Q_ENTRY_W = 1 + ERR_W;

endpackage

// ----- hw/rtl/line_follow_pd_steering.sv -----
// Line-follow PD steering: sensor beats in, wheel period commands out.
// An accepted input beat is written to the queue, then passes the five back stages.
// Throughput: one beat per cycle while m_tready is high; the front takes a beat while
// the queue (default four entries) has room; five back stages drain one a cycle.
// Reset (rst, synchronous, active high) restores register defaults, clears the
// last update time and last error, and empties the queue and pipeline.
module line_follow_pd_steering #(
  parameter int unsigned GAIN_FRACTION_BITS = lfs_pkg::GAIN_FRACTION_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH        = lfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // time_ms[31:0], left_red, left_green, left_blue, right_red, right_green,
  // right_blue (16 bits each, from bit 32 up)
  input  logic [lfs_pkg::IN_TDATA_W-1:0]     s_tdata,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // updated[0], drive_mode[2:1], left_period[18:3], right_period[34:19], zeros
  output logic [lfs_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lfs_pkg::cfg_t     cfg;
  lfs_pkg::q_entry_t front_entry;
  lfs_pkg::q_entry_t back_entry;
  logic              q_full, q_empty, q_pop, s_accept;
  logic [lfs_pkg::Q_ENTRY_W-1:0] q_rd_data;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= '0;
      cfg.deriv_gain      <= '0;
      cfg.base_period     <= '0;
      cfg.min_period      <= '0;
      cfg.max_period      <= '1;
      cfg.update_interval <= 16'd5;
      cfg.offset_on_left  <= 1'b0;
      cfg.offset_amount   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfs_pkg::REG_PROP_GAIN:       cfg.prop_gain       <= $signed(cfg_data);
        lfs_pkg::REG_DERIV_GAIN:      cfg.deriv_gain      <= $signed(cfg_data);
        lfs_pkg::REG_BASE_PERIOD:     cfg.base_period     <= cfg_data;
        lfs_pkg::REG_MIN_PERIOD:      cfg.min_period      <= cfg_data;
        lfs_pkg::REG_MAX_PERIOD:      cfg.max_period      <= cfg_data;
        lfs_pkg::REG_UPDATE_INTERVAL: cfg.update_interval <= cfg_data;
        lfs_pkg::REG_OFFSET_ON_LEFT:  cfg.offset_on_left  <= cfg_data[0];
        lfs_pkg::REG_OFFSET_AMOUNT:   cfg.offset_amount   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a beat whenever the queue has a free entry.
  assign s_tready = !q_full;
  assign s_accept = s_tvalid && s_tready;

  // Front: decide skip against the last update time and form the error.
  lfs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (s_accept),
    .tdata  (s_tdata),
    .entry  (front_entry)
  );

  // Queue decouples the front from the arithmetic pipeline.
  lfs_fifo #(
    .WIDTH (lfs_pkg::Q_ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_accept),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rd_data)
  );

  assign back_entry = q_rd_data;

  // Back: derivative, gains, truncation, dead zone, clamp and mode select.
  lfs_back #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (!q_empty),
    .q_entry   (back_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ----- hw/rtl/lfs_front.sv -----
module lfs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  lfs_pkg::cfg_t                       cfg,
  input  logic                                accept,
  input  logic [lfs_pkg::IN_TDATA_W-1:0]      tdata,
  output lfs_pkg::q_entry_t                   entry
);

  logic [lfs_pkg::TIME_W-1:0]     last_update_time;
  logic [lfs_pkg::TIME_W-1:0]     now;
  logic [lfs_pkg::TIME_W-1:0]     interval;
  logic [lfs_pkg::TIME_W-1:0]     elapsed;
  logic                           skip;
  logic [lfs_pkg::BRIGHT_W-1:0]   lb_raw, rb_raw, lb, rb, offs;

  always_comb begin
    now      = tdata[31:0];
    interval = (cfg.update_interval == '0) ? lfs_pkg::DEFAULT_INTERVAL
                                           : {16'd0, cfg.update_interval};
    elapsed  = now - last_update_time;
    skip     = (last_update_time != '0) && (elapsed < interval);

    lb_raw = {2'd0, tdata[47:32]} + {2'd0, tdata[63:48]} + {2'd0, tdata[79:64]};
    rb_raw = {2'd0, tdata[95:80]} + {2'd0, tdata[111:96]} + {2'd0, tdata[127:112]};
    offs   = {2'd0, cfg.offset_amount};
    lb = lb_raw;
    rb = rb_raw;
    // subtract the offset only when the chosen side exceeds it
    if (cfg.offset_on_left) begin
      if (lb_raw > offs) lb = lb_raw - offs;
    end else begin
      if (rb_raw > offs) rb = rb_raw - offs;
    end

    entry.updated = !skip;
    entry.err     = $signed({1'b0, rb}) - $signed({1'b0, lb});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_update_time <= '0;
    end else if (accept && !skip) begin
      last_update_time <= now;
    end
  end

endmodule

// ----- hw/rtl/lfs_fifo.sv -----
module lfs_fifo #(
  parameter int unsigned WIDTH = lfs_pkg::Q_ENTRY_W,
  parameter int unsigned DEPTH = lfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lfs_back.sv -----
module lfs_back #(
  parameter int unsigned GAIN_FRACTION_BITS = lfs_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lfs_pkg::cfg_t                      cfg,
  input  logic                               q_valid,
  input  lfs_pkg::q_entry_t                  q_entry,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lfs_pkg::OUT_TDATA_W-1:0]    out_data
);

  localparam int unsigned PP_W   = lfs_pkg::GAIN_W + lfs_pkg::ERR_W;
  localparam int unsigned DP_W   = lfs_pkg::GAIN_W + lfs_pkg::DERIV_W;
  localparam int unsigned ACC_W  = DP_W + 1;
  localparam int unsigned WIDE_W = ACC_W + 1;
  localparam logic [ACC_W-1:0] BIAS = (ACC_W'(1) << GAIN_FRACTION_BITS) - ACC_W'(1);

  logic signed [lfs_pkg::ERR_W-1:0] last_error;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic                               u1, u2, u3, u4;
  logic signed [lfs_pkg::ERR_W-1:0]   err1;
  logic signed [lfs_pkg::DERIV_W-1:0] deriv1;
  logic signed [PP_W-1:0]             pprod2;
  logic signed [DP_W-1:0]             dprod2;
  logic signed [ACC_W-1:0]            corr3;
  logic signed [WIDE_W-1:0]           lp4, rp4;

  logic signed [ACC_W-1:0]            acc, acc_b;
  logic signed [WIDE_W-1:0]           base_w, min_w, max_w, lp_c, rp_c;
  logic                               in_dead;
  logic [lfs_pkg::PERIOD_W-1:0]       lp_o, rp_o;
  logic [lfs_pkg::MODE_W-1:0]         mode_o;

  // ready ripples back from the output register
  assign r5    = !v5 || out_ready;
  assign r4    = !v4 || r5;
  assign r3    = !v3 || r4;
  assign r2    = !v2 || r3;
  assign r1    = !v1 || r2;
  assign q_pop = q_valid && r1;
  assign out_valid = v5;

  always_comb begin
    acc   = ACC_W'(pprod2) + ACC_W'(dprod2);
    // truncate toward zero: bias negatives before the arithmetic shift
    acc_b = acc + (acc[ACC_W-1] ? $signed(BIAS) : $signed(ACC_W'(0)));

    base_w  = $signed(WIDE_W'({1'b0, cfg.base_period}));
    min_w   = $signed(WIDE_W'({1'b0, cfg.min_period}));
    max_w   = $signed(WIDE_W'({1'b0, cfg.max_period}));
    in_dead = (corr3 > -ACC_W'(lfs_pkg::DEAD_ZONE)) && (corr3 < ACC_W'(lfs_pkg::DEAD_ZONE));

    lp_c = (lp4 < min_w) ? min_w : lp4;
    lp_c = (lp_c > max_w) ? max_w : lp_c;
    rp_c = (rp4 < min_w) ? min_w : rp4;
    rp_c = (rp_c > max_w) ? max_w : rp_c;
    lp_o = lp_c[lfs_pkg::PERIOD_W-1:0];
    rp_o = rp_c[lfs_pkg::PERIOD_W-1:0];
    if (lp_o < lfs_pkg::TURN_THRESHOLD || rp_o < lfs_pkg::TURN_THRESHOLD) begin
      mode_o = (lp_o < rp_o) ? lfs_pkg::MODE_TURN_RIGHT : lfs_pkg::MODE_TURN_LEFT;
    end else begin
      mode_o = lfs_pkg::MODE_FORWARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      last_error <= '0;
    end else begin
      if (r1) v1 <= q_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (q_pop && q_entry.updated) last_error <= q_entry.err;
    end
  end

  always_ff @(posedge clk) begin
    // derivative against the error of the last update
    if (r1) begin
      u1     <= q_entry.updated;
      err1   <= q_entry.err;
      deriv1 <= lfs_pkg::DERIV_W'(q_entry.err) - lfs_pkg::DERIV_W'(last_error);
    end
    if (r2) begin
      u2     <= u1;
      pprod2 <= PP_W'(cfg.prop_gain) * PP_W'(err1);
      dprod2 <= DP_W'(cfg.deriv_gain) * DP_W'(deriv1);
    end
    if (r3) begin
      u3    <= u2;
      corr3 <= acc_b >>> GAIN_FRACTION_BITS;
    end
    if (r4) begin
      u4 <= u3;
      if (in_dead) begin
        lp4 <= base_w;
        rp4 <= base_w;
      end else begin
        lp4 <= base_w + WIDE_W'(corr3);
        rp4 <= base_w - WIDE_W'(corr3);
      end
    end
    if (r5) begin
      // skipped items carry all-zero fields
      if (u4) out_data <= {5'd0, rp_o, lp_o, mode_o, 1'b1};
      else    out_data <= '0;
    end
  end

endmodule
